/* src/jcbd_pkg.sv */
// ----------------------------------------------------------------------------
// JPEG coefficient block decoder package
// Shared widths, command and state codes, the zigzag table and the
// magnitude sign-extension used by the block decoder.
// ----------------------------------------------------------------------------
package jcbd_pkg;

  localparam int IDX_W   = 6;    // coefficient position within a block
  localparam int POS_W   = 7;    // scan position, wide enough to hold the block length
  localparam int COEF_W  = 16;
  localparam int QUANT_W = 16;
  localparam int VALUE_W = 32;
  localparam int EXTRA_W = 15;
  localparam int BLOCK_LEN = 64;

  localparam logic [POS_W-1:0] POS_FULL   = 7'd64;
  localparam logic [POS_W-1:0] POS_LAST   = 7'd63;
  localparam logic [POS_W-1:0] ZRL_SKIP   = 7'd16;
  localparam logic [7:0]       MAX_DC_CAT = 8'd11;
  localparam logic [3:0]       ZRL_RUN    = 4'hF;
  localparam logic [IDX_W-1:0] IDX_LAST   = 6'd63;

  typedef enum logic [1:0] {
    CMD_SYMBOL   = 2'd0,
    CMD_QLOAD    = 2'd1,
    CMD_DC_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EMIT = 2'd1,
    ST_ERR  = 2'd2
  } state_t;

  // Zigzag position to natural (row-major) position.
  localparam logic [IDX_W-1:0] ZZ_TO_NAT [BLOCK_LEN] = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

  // Baseline EXTEND of the low s bits of raw. A size of zero gives zero.
  function automatic logic signed [COEF_W-1:0] extend_bits(input logic [EXTRA_W-1:0] raw,
                                                           input logic [3:0] s);
    logic [COEF_W-1:0] mask;
    logic [COEF_W-1:0] v;
    logic              msb;
    mask = (16'd1 << s) - 16'd1;
    v    = {1'b0, raw} & mask;
    msb  = |(v & (mask ^ (mask >> 1)));
    extend_bits = msb ? $signed(v) : $signed(v - mask);
  endfunction

endpackage

/* src/jcbd_ifs.sv */
// ----------------------------------------------------------------------------
// JPEG coefficient block decoder channels
// Valid/ready channels for the symbol input and the coefficient output.
// ----------------------------------------------------------------------------
interface jcbd_in_if import jcbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [7:0]         symbol;
  logic [EXTRA_W-1:0] extra_bits;
  logic [IDX_W-1:0]   quant_index;
  logic [QUANT_W-1:0] quant_value;

  modport source(output valid, cmd, symbol, extra_bits, quant_index, quant_value,
                 input ready);
  modport sink(input valid, cmd, symbol, extra_bits, quant_index, quant_value,
               output ready);
endinterface

interface jcbd_out_if import jcbd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [IDX_W-1:0]          coef_index;
  logic signed [VALUE_W-1:0] coef_value;
  logic                      status;
  logic                      last;

  modport source(output valid, coef_index, coef_value, status, last, input ready);
  modport sink(input valid, coef_index, coef_value, status, last, output ready);
endinterface

/* src/jcbd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jcbd_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/jpeg_coefficient_block_decoder.sv */
// ----------------------------------------------------------------------------
// JPEG coefficient block decoder
// Builds one 8x8 block of coefficients from decoded DC/AC symbols and
// streams it out dequantized, in zigzag order, tagged with natural positions.
// ----------------------------------------------------------------------------
// A symbol, table load or predictor clear is taken whenever the block is idle,
// even while the previous result word still waits at the output. When a block
// completes (end of block, a zero run reaching the end, or the last position
// filled), the block stops taking words and streams 64 result words. Each word
// passes the registered read of the coefficient and quantization memories,
// then the single shared multiplier into the output register; the next entry
// is read only after the previous word is loaded, and an output stall holds
// the stream. A stream error yields one error word, loaded once the output is
// free. Coefficient storage is cleared at once after readout or an error
// through per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module jpeg_coefficient_block_decoder
  import jcbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  jcbd_in_if.sink     in_ch,
  jcbd_out_if.source  out_ch
);

  state_t                    state_r, state_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic signed [COEF_W-1:0]  dc_pred_r, dc_pred_nxt;
  logic [IDX_W-1:0]          k_r, k_nxt;
  logic                      rd_ok_r, rd_ok_nxt;
  logic [BLOCK_LEN-1:0]      valid_r, valid_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]          out_idx_r, out_idx_nxt;
  logic signed [VALUE_W-1:0] out_val_r, out_val_nxt;
  logic                      out_status_r, out_status_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      accept, is_sym, dc_phase, bad_dc;
  logic                      ac_zrl, ac_eob, go_err, go_emit;
  logic                      out_free, load;
  logic [3:0]                run, size;
  logic [POS_W-1:0]          run_pos, zrl_pos;
  logic signed [COEF_W-1:0]  dc_ext, ac_ext, dc_sat;
  logic signed [COEF_W:0]    dc_sum;

  logic                      coef_we, quant_we;
  logic [IDX_W-1:0]          coef_waddr;
  logic [COEF_W-1:0]         coef_wdata, coef_rdata;
  logic [QUANT_W-1:0]        quant_rdata;
  logic signed [COEF_W-1:0]  coef_eff;
  logic signed [VALUE_W:0]   product;

  jcbd_ram #(.Width(COEF_W), .Depth(BLOCK_LEN)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (k_r),
    .rdata (coef_rdata)
  );

  jcbd_ram #(.Width(QUANT_W), .Depth(BLOCK_LEN)) u_quant_ram (
    .clk   (clk),
    .we    (quant_we),
    .waddr (in_ch.quant_index),
    .wdata (in_ch.quant_value),
    .raddr (k_r),
    .rdata (quant_rdata)
  );

  // Symbol decode.
  always_comb begin
    accept   = in_ch.valid && in_ch.ready;
    is_sym   = accept && (in_ch.cmd == CMD_SYMBOL);
    dc_phase = (pos_r == '0);
    bad_dc   = (in_ch.symbol > MAX_DC_CAT);
    run      = in_ch.symbol[7:4];
    size     = in_ch.symbol[3:0];
    ac_zrl   = (size == 4'd0) && (run == ZRL_RUN);
    ac_eob   = (size == 4'd0) && !ac_zrl;
    run_pos  = pos_r + {3'd0, run};
    zrl_pos  = pos_r + ZRL_SKIP;

    dc_ext = extend_bits(in_ch.extra_bits, size);
    ac_ext = dc_ext;
    dc_sum = {dc_pred_r[COEF_W-1], dc_pred_r} + {dc_ext[COEF_W-1], dc_ext};
    if (dc_sum[COEF_W] != dc_sum[COEF_W-1]) begin
      dc_sat = dc_sum[COEF_W] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      dc_sat = dc_sum[COEF_W-1:0];
    end

    if (dc_phase) begin
      go_err  = is_sym && bad_dc;
      go_emit = 1'b0;
    end else if (ac_zrl) begin
      go_err  = is_sym && (zrl_pos > POS_FULL);
      go_emit = is_sym && (zrl_pos == POS_FULL);
    end else if (ac_eob) begin
      go_err  = 1'b0;
      go_emit = is_sym;
    end else begin
      go_err  = is_sym && (run_pos >= POS_FULL);
      go_emit = is_sym && (run_pos == POS_LAST);
    end
  end

  // Readout: an entry that was not written since the last clear reads as zero.
  always_comb begin
    out_free = !out_valid_r || out_ch.ready;
    load     = (state_r == ST_EMIT) && rd_ok_r && out_free;
    coef_eff = valid_r[k_r] ? $signed(coef_rdata) : '0;
    product  = coef_eff * $signed({1'b0, quant_rdata});
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (go_err) begin
          state_nxt = ST_ERR;
        end else if (go_emit) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load && (k_r == IDX_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    in_ch.ready    = (state_r == ST_IDLE);
    pos_nxt        = pos_r;
    dc_pred_nxt    = dc_pred_r;
    k_nxt          = k_r;
    valid_nxt      = valid_r;
    rd_ok_nxt      = (state_r == ST_EMIT) && !load;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_idx_nxt    = out_idx_r;
    out_val_nxt    = out_val_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    coef_we        = 1'b0;
    coef_waddr     = '0;
    coef_wdata     = dc_sat;
    quant_we       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.cmd)
            CMD_QLOAD:    quant_we    = 1'b1;
            CMD_DC_CLEAR: dc_pred_nxt = '0;
            CMD_SYMBOL: begin
              if (go_err) begin
                valid_nxt = '0;
                pos_nxt   = '0;
              end else if (dc_phase) begin
                dc_pred_nxt = dc_sat;
                coef_we     = 1'b1;
                valid_nxt[0] = 1'b1;
                pos_nxt     = 7'd1;
              end else if (ac_zrl) begin
                if (!go_emit) begin
                  pos_nxt = zrl_pos;
                end
              end else if (!ac_eob) begin
                coef_we    = 1'b1;
                coef_waddr = run_pos[IDX_W-1:0];
                coef_wdata = ac_ext;
                valid_nxt[run_pos[IDX_W-1:0]] = 1'b1;
                pos_nxt    = run_pos + 7'd1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = ZZ_TO_NAT[k_r];
          out_val_nxt    = product[VALUE_W-1:0];
          out_status_nxt = 1'b0;
          out_last_nxt   = (k_r == IDX_LAST);
          k_nxt          = k_r + 6'd1;
          if (k_r == IDX_LAST) begin
            valid_nxt = '0;
            pos_nxt   = '0;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = '0;
          out_val_nxt    = '0;
          out_status_nxt = 1'b1;
          out_last_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      dc_pred_r   <= '0;
      k_r         <= '0;
      rd_ok_r     <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      dc_pred_r   <= dc_pred_nxt;
      k_r         <= k_nxt;
      rd_ok_r     <= rd_ok_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r    <= out_idx_nxt;
    out_val_r    <= out_val_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.coef_index = out_idx_r;
  assign out_ch.coef_value = out_val_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.last       = out_last_r;

endmodule
